[sv/ntc_table_lookup_averager_assert.svh]
// Assertion macros used by the thermistor averager RTL.
// Included by ntc_table_lookup_averager to check its own sequencing; needs nothing else.
`ifndef NTC_TABLE_LOOKUP_AVERAGER_ASSERT_SVH
`define NTC_TABLE_LOOKUP_AVERAGER_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define NTCLA_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define NTCLA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NTCLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/ntcla_pkg.sv]
// Shared types, constants and the thermistor code table of the averager.
// Used by ntcla_div and ntc_table_lookup_averager; depends on nothing.
package ntcla_pkg;

	localparam int SampleWidth   = 12;
	localparam int TempWidth     = 8;
	localparam int OffsetWidth   = 6;
	localparam int SumWidth      = 12;
	localparam int TableSlots    = 128;
	localparam int TableIdxWidth = 7;
	localparam int SamplesDefault = 20;
	localparam int EntriesDefault = 120;
	localparam int IndexBias     = 20;

	// Ascending converter codes; entry k stands for (k - 20) degrees C.
	localparam logic [SampleWidth-1:0] NtcCodes [TableSlots] = '{
		12'd498,  12'd521,  12'd544,  12'd568,  12'd593,
		12'd618,  12'd645,  12'd672,  12'd700,  12'd728,
		12'd757,  12'd787,  12'd818,  12'd849,  12'd881,
		12'd914,  12'd947,  12'd981,  12'd1015, 12'd1050,
		12'd1085, 12'd1121, 12'd1157, 12'd1194, 12'd1231,
		12'd1268, 12'd1306, 12'd1344, 12'd1388, 12'd1421,
		12'd1454, 12'd1499, 12'd1538, 12'd1578, 12'd1617,
		12'd1656, 12'd1696, 12'd1735, 12'd1775, 12'd1814,
		12'd1854, 12'd1896, 12'd1932, 12'd1971, 12'd2010,
		12'd2048, 12'd2086, 12'd2124, 12'd2162, 12'd2200,
		12'd2237, 12'd2274, 12'd2310, 12'd2346, 12'd2382,
		12'd2417, 12'd2452, 12'd2487, 12'd2521, 12'd2554,
		12'd2587, 12'd2620, 12'd2652, 12'd2684, 12'd2715,
		12'd2746, 12'd2777, 12'd2806, 12'd2836, 12'd2865,
		12'd2893, 12'd2920, 12'd2948, 12'd2975, 12'd3001,
		12'd3027, 12'd3052, 12'd3077, 12'd3101, 12'd3125,
		12'd3148, 12'd3171, 12'd3193, 12'd3215, 12'd3237,
		12'd3258, 12'd3278, 12'd3298, 12'd3318, 12'd3337,
		12'd3355, 12'd3374, 12'd3392, 12'd3409, 12'd3426,
		12'd3443, 12'd3459, 12'd3475, 12'd3490, 12'd3505,
		12'd3520, 12'd3534, 12'd3548, 12'd3562, 12'd3575,
		12'd3586, 12'd3601, 12'd3613, 12'd3625, 12'd3637,
		12'd3648, 12'd3659, 12'd3670, 12'd3681, 12'd3691,
		12'd3701, 12'd3711, 12'd3720, 12'd3729, 12'd3739,
		12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
		12'd4095, 12'd4095, 12'd4095
	};

	function automatic logic [SampleWidth-1:0] ntc_code(input logic [TableIdxWidth-1:0] idx);
		return NtcCodes[idx];
	endfunction

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WALK = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

[sv/ntcla_div.sv]
// Divider of the index sum by a constant block length, by reciprocal multiplication.
// Depends on ntcla_pkg for the sum width and the status struct.
module ntcla_div
	import ntcla_pkg::*;
#(
	parameter int Divisor = SamplesDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SumWidth-1:0] dividend,
	output div_sts_t            sts,
	output logic [SumWidth-1:0] quotient
);

	// The reciprocal is rounded up and scaled far enough that the truncated product
	// equals the quotient for every sum that fits in SumWidth bits.
	localparam int RecipShift = SumWidth + $clog2(Divisor);
	localparam int ProdWidth  = RecipShift + SumWidth;
	localparam logic [ProdWidth-1:0] RecipMul =
		ProdWidth'(((1 << RecipShift) + Divisor - 1) / Divisor);

	logic                 busy_q;
	logic                 done_q;
	logic [SumWidth-1:0]  dvd_q;
	logic [SumWidth-1:0]  quo_q;
	logic [ProdWidth-1:0] product;

	assign product = ProdWidth'(dvd_q) * RecipMul;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start;
			done_q <= busy_q;
		end
	end

	// The sum is latched first so the multiply starts from a register.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
		end
		if (busy_q) begin
			quo_q <= product[ProdWidth-1 -: SumWidth];
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quo_q;

endmodule

[sv/ntc_table_lookup_averager.sv]
// Top level: NTC sample table lookup with rounding, block averaging and offset.
// Depends on ntcla_pkg, ntcla_div and ntc_table_lookup_averager_assert.svh.
//
//   Channel      | Direction | Carries
//   s_axis       | in        | adc_sample
//   m_axis       | out       | temperature_c
//   temp_offset  | in        | compensation register write
//
// A looked-up sample is accepted and range-checked, then the table is walked entry by
// entry up to the first entry not below the sample. A sample outside the table is
// accepted and dropped without a walk. An emitting item passes through the accept, the
// reciprocal multiply, the divider handoff and the output register load, plus any
// wait for the output register to free up.
// Reset clears the count, sum, offset and output valid. Input ready is low while busy.
`include "ntc_table_lookup_averager_assert.svh"

module ntc_table_lookup_averager
	import ntcla_pkg::*;
#(
	parameter int SAMPLES_PER_RESULT = SamplesDefault,
	parameter int TABLE_ENTRIES      = EntriesDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   temp_offset_we,
	input  logic [OffsetWidth-1:0] temp_offset,   // temp_offset, two's complement
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [15:0]            s_axis_tdata,  // [11:0] adc_sample, [15:12] zero
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [TempWidth-1:0]   m_axis_tdata   // [7:0] temperature_c
);

	localparam int CntWidth = $clog2(SAMPLES_PER_RESULT + 1);
	localparam int IdxWidth = $clog2(TABLE_ENTRIES);
	localparam logic [CntWidth-1:0] CntFull = CntWidth'(SAMPLES_PER_RESULT);
	localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(TABLE_ENTRIES - 1);
	localparam int CalcWidth = 14;

	state_t                  state_q;
	logic [CntWidth-1:0]     count_q;
	logic [SumWidth-1:0]     sum_q;
	logic [OffsetWidth-1:0]  offset_q;
	logic [SampleWidth-1:0]  sample_q;
	logic [IdxWidth-1:0]     walk_idx_q;
	logic                    out_valid_q;
	logic [TempWidth-1:0]    out_data_q;

	logic                    in_xfer;
	logic [SampleWidth-1:0]  in_sample;
	logic                    in_range;
	logic                    emit_item;
	logic [SampleWidth-1:0]  code_hi;
	logic [SampleWidth-1:0]  code_lo;
	logic [SampleWidth-1:0]  span_half;
	logic [SampleWidth-1:0]  above_lo;
	logic [IdxWidth-1:0]     pick_idx;
	logic                    div_start;
	div_sts_t                div_sts;
	logic [SumWidth-1:0]     quotient;
	logic signed [CalcWidth-1:0] temp_wide;
	logic [TempWidth-1:0]    temp_sat;
	logic                    out_free;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign in_sample     = s_axis_tdata[SampleWidth-1:0];
	assign emit_item     = (count_q == CntFull);
	assign in_range      = (in_sample > ntc_code('0)) &&
	                       (in_sample < ntc_code(TableIdxWidth'(LastIdx)));
	assign div_start     = in_xfer && emit_item;
	assign out_free      = !out_valid_q || m_axis_tready;

	// Walk compare: rounds down unless the sample sits past half the step.
	assign code_hi   = ntc_code(TableIdxWidth'(walk_idx_q));
	assign code_lo   = ntc_code(TableIdxWidth'(walk_idx_q - IdxWidth'(1)));
	assign span_half = (code_hi - code_lo) >> 1;
	assign above_lo  = sample_q - code_lo;
	assign pick_idx  = (above_lo > span_half) ? walk_idx_q : walk_idx_q - IdxWidth'(1);

	assign temp_wide = $signed({2'b00, quotient})
	                 - CalcWidth'(IndexBias)
	                 - {{(CalcWidth - OffsetWidth){offset_q[OffsetWidth-1]}}, offset_q};

	always_comb begin
		if (temp_wide > CalcWidth'(127)) begin
			temp_sat = 8'h7F;
		end else if (temp_wide < -CalcWidth'(128)) begin
			temp_sat = 8'h80;
		end else begin
			temp_sat = temp_wide[TempWidth-1:0];
		end
	end

	ntcla_div #(
		.Divisor (SAMPLES_PER_RESULT)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.sts      (div_sts),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			sum_q       <= '0;
			offset_q    <= '0;
			walk_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (temp_offset_we) begin
				offset_q <= temp_offset;
			end
			// A new result may only load once the previous transfer has gone out.
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (emit_item) begin
							state_q <= ST_DIV;
						end else if (in_range) begin
							walk_idx_q <= IdxWidth'(1);
							state_q    <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (code_hi >= sample_q) begin
						sum_q   <= sum_q + SumWidth'(pick_idx);
						count_q <= count_q + CntWidth'(1);
						state_q <= ST_IDLE;
					end else begin
						walk_idx_q <= walk_idx_q + IdxWidth'(1);
					end
				end
				ST_DIV: begin
					if (div_sts.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						count_q     <= '0;
						sum_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q <= in_sample;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_data_q <= temp_sat;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`NTCLA_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CntFull, "sample count past block length")
	`NTCLA_ASSERT_IMPL(a_div_done_state, clk, arst_n, div_sts.done, state_q == ST_DIV, "divider finished outside divide state")
	`NTCLA_ASSERT_IMPL(a_walk_bound, clk, arst_n, state_q == ST_WALK, (walk_idx_q != '0) && (walk_idx_q <= LastIdx), "table walk left the table")
	`NTCLA_ASSERT_NEXT(a_emit_starts_div, clk, arst_n, div_start, div_sts.busy && (state_q == ST_DIV), "emitting item did not start the divider")

endmodule

[tb/tb_ntc_table_lookup_averager.sv]
// Self-checking testbench for ntc_table_lookup_averager: streams thermistor samples,
// predicts each averaged temperature and checks the output stream against it.
// Depends on ntcla_pkg and the ntc_table_lookup_averager RTL.
`timescale 1ns / 100ps

module tb_ntc_table_lookup_averager
	import ntcla_pkg::*;
();

	localparam int BlockLen     = 20;
	localparam int TableLen     = 120;
	localparam int TempBias     = 20;
	localparam int SettleCycles = 200;
	localparam int RandomItems  = 850;
	localparam int MinResults   = 40;

	// Window kinds used to steer the random samples through the table.
	localparam int WinFull = 0;
	localparam int WinHot  = 1;
	localparam int WinCold = 2;
	localparam int WinBand = 3;

	// Thermistor codes, ascending; entry k stands for (k - 20) degrees C.
	localparam logic [11:0] ThermCodes [128] = '{
		12'd498,  12'd521,  12'd544,  12'd568,  12'd593,  12'd618,  12'd645,  12'd672,
		12'd700,  12'd728,  12'd757,  12'd787,  12'd818,  12'd849,  12'd881,  12'd914,
		12'd947,  12'd981,  12'd1015, 12'd1050, 12'd1085, 12'd1121, 12'd1157, 12'd1194,
		12'd1231, 12'd1268, 12'd1306, 12'd1344, 12'd1388, 12'd1421, 12'd1454, 12'd1499,
		12'd1538, 12'd1578, 12'd1617, 12'd1656, 12'd1696, 12'd1735, 12'd1775, 12'd1814,
		12'd1854, 12'd1896, 12'd1932, 12'd1971, 12'd2010, 12'd2048, 12'd2086, 12'd2124,
		12'd2162, 12'd2200, 12'd2237, 12'd2274, 12'd2310, 12'd2346, 12'd2382, 12'd2417,
		12'd2452, 12'd2487, 12'd2521, 12'd2554, 12'd2587, 12'd2620, 12'd2652, 12'd2684,
		12'd2715, 12'd2746, 12'd2777, 12'd2806, 12'd2836, 12'd2865, 12'd2893, 12'd2920,
		12'd2948, 12'd2975, 12'd3001, 12'd3027, 12'd3052, 12'd3077, 12'd3101, 12'd3125,
		12'd3148, 12'd3171, 12'd3193, 12'd3215, 12'd3237, 12'd3258, 12'd3278, 12'd3298,
		12'd3318, 12'd3337, 12'd3355, 12'd3374, 12'd3392, 12'd3409, 12'd3426, 12'd3443,
		12'd3459, 12'd3475, 12'd3490, 12'd3505, 12'd3520, 12'd3534, 12'd3548, 12'd3562,
		12'd3575, 12'd3586, 12'd3601, 12'd3613, 12'd3625, 12'd3637, 12'd3648, 12'd3659,
		12'd3670, 12'd3681, 12'd3691, 12'd3701, 12'd3711, 12'd3720, 12'd3729, 12'd3739,
		12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095
	};

	class avg_temp_scoreboard;
		logic signed [OffsetWidth-1:0] offset_reg;
		int                            block_count;
		logic [11:0]                   index_sum;
		logic [TempWidth-1:0]          expected_temps [$];
		int                            errors;
		int                            samples_seen;
		int                            samples_dropped;
		int                            temps_checked;

		function new();
			offset_reg      = '0;
			block_count     = 0;
			index_sum       = '0;
			errors          = 0;
			samples_seen    = 0;
			samples_dropped = 0;
			temps_checked   = 0;
		endfunction

		function void set_offset(logic signed [OffsetWidth-1:0] value);
			offset_reg = value;
		endfunction

		function int pending();
			return expected_temps.size();
		endfunction

		// Called for every accepted input transfer.
		function void note_sample(logic [11:0] code);
			int i;
			int lower;
			int half;
			int idx;
			int temp;
			samples_seen++;
			if (block_count < BlockLen) begin
				if (code <= ThermCodes[0] || code >= ThermCodes[TableLen-1]) begin
					samples_dropped++;
					return;
				end
				for (i = 1; i < TableLen; i++)
					if (ThermCodes[i] >= code)
						break;
				lower = ThermCodes[i-1];
				half  = (int'(ThermCodes[i]) - lower) / 2;
				// A sample exactly at the midpoint rounds down to the lower entry.
				idx = ((int'(code) - lower) > half) ? i : i - 1;
				index_sum = index_sum + idx[11:0];
				block_count++;
			end else begin
				// This transfer carries no sample; it releases the average.
				temp = int'(index_sum) / BlockLen - TempBias - int'(offset_reg);
				if (temp > 127)
					temp = 127;
				if (temp < -128)
					temp = -128;
				expected_temps.push_back(temp[TempWidth-1:0]);
				block_count = 0;
				index_sum   = '0;
			end
		endfunction

		function void check_result(logic [TempWidth-1:0] got);
			logic [TempWidth-1:0] want;
			if (expected_temps.size() == 0) begin
				errors++;
				$display("%0t: unexpected temperature %0d", $time, $signed(got));
				return;
			end
			want = expected_temps.pop_front();
			temps_checked++;
			if (got !== want) begin
				errors++;
				$display("%0t: temperature_c expected %0d, got %0d",
					$time, $signed(want), $signed(got));
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   temp_offset_we;
	logic [OffsetWidth-1:0] temp_offset;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [15:0]            s_axis_tdata;   // [11:0] adc_sample, [15:12] zero
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [TempWidth-1:0]   m_axis_tdata;   // [7:0] temperature_c

	avg_temp_scoreboard board;
	bit                 no_idle;
	int                 items_sent;
	int                 offsets_used;

	ntc_table_lookup_averager #(
		.SAMPLES_PER_RESULT(BlockLen),
		.TABLE_ENTRIES(TableLen)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.temp_offset_we(temp_offset_we),
		.temp_offset(temp_offset),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("ntc_table_lookup_averager: mismatch");
		$finish;
	end

	always @(negedge clk) begin
		m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 6);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tdata);
	end

	// Starts and ends at a falling edge; leaves tvalid high for a following sample.
	task automatic push_sample(input logic [11:0] code);
		if (!no_idle && $urandom_range(0, 99) < 6) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0000, code};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		board.note_sample(code);
		items_sent++;
		@(negedge clk);
	endtask

	// Lets the last transfer drain and any table walk finish before a register write.
	task automatic wait_quiet();
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_offset(input logic signed [OffsetWidth-1:0] value);
		temp_offset_we <= 1'b1;
		temp_offset    <= value;
		@(negedge clk);
		temp_offset_we <= 1'b0;
		board.set_offset(value);
		offsets_used++;
	endtask

	function automatic logic [11:0] pick_sample(int window, int band_lo);
		logic [11:0] code;
		// A few samples fall on or beyond the table ends and must be dropped.
		if ($urandom_range(0, 99) < 5)
			code = $urandom_range(0, 1) ? 12'($urandom_range(0, 498))
				: 12'($urandom_range(3739, 4095));
		else begin
			case (window)
				WinHot:  code = 12'($urandom_range(3690, 3738));
				WinCold: code = 12'($urandom_range(499, 620));
				WinBand: code = 12'($urandom_range(band_lo, band_lo + 99));
				default: code = 12'($urandom_range(499, 3738));
			endcase
		end
		return code;
	endfunction

	initial begin
		logic [11:0] directed_codes [$];
		logic signed [OffsetWidth-1:0] phase_offsets [$];
		int phase;
		int n;
		int window;
		int band_lo;

		board          = new();
		no_idle        = 1'b0;
		items_sent     = 0;
		offsets_used   = 0;
		arst_n         = 1'b0;
		temp_offset_we = 1'b0;
		temp_offset    = '0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		m_axis_tready  = 1'b1;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Table ends, the values just inside them, exact entries and both sides of a
		// rounding midpoint; twenty samples are accepted so the last one emits.
		directed_codes = '{12'd0, 12'd4095, 12'd498, 12'd3739, 12'd3800,
			12'd499, 12'd509, 12'd510, 12'd521, 12'd1050, 12'd1388, 12'd2048,
			12'd3738, 12'd3730, 12'd3734, 12'd3735, 12'd3720, 12'd3725, 12'd2000,
			12'd1000, 12'd600, 12'd3000, 12'd3500, 12'd2500, 12'd1500, 12'd0};
		write_offset(6'sd7);
		foreach (directed_codes[k])
			push_sample(directed_codes[k]);
		wait_quiet();

		phase_offsets = '{-6'sd32, 6'sd31, -6'sd20, 6'sd20, 6'sd0, -6'sd1};
		phase = 0;
		while (items_sent < RandomItems + directed_codes.size()
				|| board.temps_checked < MinResults) begin
			if (phase < phase_offsets.size())
				write_offset(phase_offsets[phase]);
			else
				write_offset(6'($urandom_range(0, 63)));
			// One phase runs with no idle cycles on either side.
			no_idle = (phase == 2);
			window  = $urandom_range(WinFull, WinBand);
			if (phase == 1)
				window = WinHot;
			band_lo = $urandom_range(499, 3639);
			for (n = 0; n < 90; n++)
				push_sample(pick_sample(window, band_lo));
			wait_quiet();
			phase++;
		end
		no_idle = 1'b0;

		$display("Sent %0d samples, %0d outside the table, through %0d offset settings.",
			board.samples_seen, board.samples_dropped, offsets_used);
		$display("Checked %0d averaged temperatures.", board.temps_checked);
		if (board.errors == 0 && board.pending() == 0)
			$display("ntc_table_lookup_averager: match");
		else
			$display("ntc_table_lookup_averager: mismatch");
		$finish;
	end

endmodule
